/* hdl/tad_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tad_pkg
// types, codes and constants shared by the timer and interrupt dispatch block
// ----------------------------------------------------------------------------
package tad_pkg;

    localparam int unsigned SOURCES    = 5;
    localparam int unsigned SRC_W      = 3;
    localparam int unsigned DIV_PRE_W  = 6;
    localparam int unsigned TIMER_PRE_W = 9;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_SERVICE = 2'd2;

    localparam logic [1:0] REG_TIMER_CONTROL    = 2'd0;
    localparam logic [1:0] REG_TIMER_MODULO     = 2'd1;
    localparam logic [1:0] REG_INTERRUPT_ENABLE = 2'd2;

    localparam logic [DIV_PRE_W-1:0] DIV_LAST        = 6'd63;
    localparam logic [SRC_W-1:0]     TIMER_SOURCE    = 3'd2;
    localparam logic [SRC_W-1:0]     LAST_SOURCE     = 3'd4;
    localparam logic [6:0]           VECTOR_BASE     = 7'h40;
    localparam logic [2:0]           DISPATCH_CYCLES = 3'd5;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_STEP
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  request_bit;
        logic        master_enable;
        logic        latch;
        logic [15:0] program_counter;
    } cmd_t;

    typedef struct packed {
        logic        taken;
        logic [15:0] return_address;
        logic [6:0]  vector;
        logic [2:0]  cycles;
        logic        wake;
        logic [4:0]  pending_flags;
        logic [7:0]  divider;
        logic [7:0]  timer_count;
    } res_t;

    function automatic logic [TIMER_PRE_W-1:0] timer_period(input logic [1:0] sel);
        logic [TIMER_PRE_W-1:0] p;
        unique case (sel)
            2'd0: p = 9'd256;
            2'd1: p = 9'd4;
            2'd2: p = 9'd16;
            2'd3: p = 9'd64;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

/* hdl/timer_and_interrupt_dispatch.sv */
`timescale 1ns / 1ps
`default_nettype none
// Items are taken one at a time. A request, a service check, or a tick while
// the timer is off gives its result in the output register at the accepting
// edge, so such items run at one per cycle when the result side keeps up. A
// tick while the timer is on enters the step state, where one subtract-compare
// step unit retires one prescaler period per cycle until the prescaler is
// below the period, then loads the result (0 or 1 periods in steady running,
// up to 64 after a period change). APB registers at byte addresses 0, 4, 8.
// ----------------------------------------------------------------------------
// timer_and_interrupt_dispatch
// divider, programmable timer and interrupt flag/dispatch logic
// ----------------------------------------------------------------------------
module timer_and_interrupt_dispatch (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire tad_pkg::cmd_t cmd,
    output logic               res_valid,
    input  wire logic          res_ready,
    output tad_pkg::res_t      res,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    tad_pkg::state_t state_reg, state_next;
    logic [2:0]  tc_reg;
    logic [7:0]  tma_reg;
    logic [7:0]  ie_reg;
    logic [tad_pkg::DIV_PRE_W-1:0]   dp_reg, dp_next;
    logic [7:0]                      dv_reg, dv_next;
    logic [tad_pkg::TIMER_PRE_W-1:0] tp_reg, tp_next;
    logic [7:0]                      tv_reg, tv_next;
    logic [tad_pkg::SOURCES-1:0]     flags_reg, flags_next;
    logic                            res_valid_reg, res_valid_next;
    tad_pkg::res_t                   res_reg, res_next;

    logic                            cfg_write;
    logic [tad_pkg::SOURCES-1:0]     active;
    logic [tad_pkg::SRC_W-1:0]       low_bit;
    logic [tad_pkg::TIMER_PRE_W-1:0] period;
    logic                            load_res;
    tad_pkg::res_t                   res_build;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cmd_ready = (state_reg == tad_pkg::ST_IDLE) && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg  <= '0;
            tma_reg <= '0;
            ie_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                tad_pkg::REG_TIMER_CONTROL:    tc_reg  <= pwdata[2:0];
                tad_pkg::REG_TIMER_MODULO:     tma_reg <= pwdata[7:0];
                tad_pkg::REG_INTERRUPT_ENABLE: ie_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            tad_pkg::REG_TIMER_CONTROL:    prdata = {29'd0, tc_reg};
            tad_pkg::REG_TIMER_MODULO:     prdata = {24'd0, tma_reg};
            tad_pkg::REG_INTERRUPT_ENABLE: prdata = {24'd0, ie_reg};
            default:                       prdata = '0;
        endcase
    end

    // lowest enabled pending source
    assign active = ie_reg[tad_pkg::SOURCES-1:0] & flags_reg;
    always_comb
    begin
        low_bit = '0;
        for (int i = tad_pkg::SOURCES - 1; i >= 0; i--)
        begin
            if (active[i])
            begin
                low_bit = tad_pkg::SRC_W'(i);
            end
        end
    end

    assign period = tad_pkg::timer_period(tc_reg[1:0]);

    always_comb
    begin
        state_next     = state_reg;
        dp_next        = dp_reg;
        dv_next        = dv_reg;
        tp_next        = tp_reg;
        tv_next        = tv_reg;
        flags_next     = flags_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        load_res       = 1'b0;
        res_build      = '0;

        unique case (state_reg)
            tad_pkg::ST_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    unique case (cmd.kind)
                        tad_pkg::KIND_TICK:
                        begin
                            dp_next = dp_reg + 1'b1;
                            if (dp_reg == tad_pkg::DIV_LAST)
                            begin
                                dv_next = dv_reg + 1'b1;
                            end
                            if (tc_reg[2])
                            begin
                                tp_next    = tp_reg + 1'b1;
                                state_next = tad_pkg::ST_STEP;
                            end
                            else
                            begin
                                load_res = 1'b1;
                            end
                        end
                        tad_pkg::KIND_REQUEST:
                        begin
                            if (cmd.request_bit <= tad_pkg::LAST_SOURCE)
                            begin
                                flags_next = flags_reg
                                           | (tad_pkg::SOURCES'(1) << cmd.request_bit);
                            end
                            load_res = 1'b1;
                        end
                        tad_pkg::KIND_SERVICE:
                        begin
                            if (cmd.master_enable && cmd.latch)
                            begin
                                res_build.taken          = 1'b1;
                                res_build.return_address = cmd.program_counter;
                                res_build.cycles         = tad_pkg::DISPATCH_CYCLES;
                                res_build.wake           = 1'b1;
                                if (active != '0)
                                begin
                                    res_build.vector = tad_pkg::VECTOR_BASE
                                                     + 7'({low_bit, 3'b000});
                                    flags_next = flags_reg
                                               & ~(tad_pkg::SOURCES'(1) << low_bit);
                                end
                            end
                            else if (active != '0)
                            begin
                                res_build.wake = 1'b1;
                            end
                            load_res = 1'b1;
                        end
                        default:
                        begin
                            load_res = 1'b1;
                        end
                    endcase
                end
            end
            tad_pkg::ST_STEP:
            begin
                // one prescaler period retired per cycle
                if (tp_reg >= period)
                begin
                    tp_next = tp_reg - period;
                    tv_next = tv_reg + 1'b1;
                    if (tv_reg == 8'hFF)
                    begin
                        tv_next    = tma_reg;
                        flags_next = flags_reg
                                   | (tad_pkg::SOURCES'(1) << tad_pkg::TIMER_SOURCE);
                    end
                end
                else
                begin
                    load_res   = 1'b1;
                    state_next = tad_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tad_pkg::ST_IDLE;
            end
        endcase

        if (load_res)
        begin
            res_build.pending_flags = flags_next;
            res_build.divider       = dv_next;
            res_build.timer_count   = tv_next;
            res_next                = res_build;
            res_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tad_pkg::ST_IDLE;
            dp_reg        <= '0;
            dv_reg        <= '0;
            tp_reg        <= '0;
            tv_reg        <= '0;
            flags_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dp_reg        <= dp_next;
            dv_reg        <= dv_next;
            tp_reg        <= tp_next;
            tv_reg        <= tv_next;
            flags_reg     <= flags_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_no_result_while_stepping: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tad_pkg::ST_STEP) |-> !res_valid_reg)
        else $error("result pending during timer catch-up");

    a_step_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tad_pkg::ST_IDLE && $past(state_reg) == tad_pkg::ST_STEP)
        |-> res_valid_reg)
        else $error("timer catch-up finished without a result");

    a_accept_only_with_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |-> (!res_valid_reg || res_ready))
        else $error("item accepted while output register full");

    a_step_leaves_prescaler_below_period: assert property (@(posedge clk)
        disable iff (!rst_n)
        (state_reg == tad_pkg::ST_STEP && tp_reg < period) |=> res_valid_reg)
        else $error("no result after prescaler caught up");
`endif

endmodule
`default_nettype wire
